/* src/psb_pkg.sv */
package psb_pkg;

  localparam int CW = 7;
  localparam int DW = 32;

  localparam logic [2:0] F_INSERT = 3'd0;
  localparam logic [2:0] F_REMOVE = 3'd1;
  localparam logic [2:0] F_MOVE   = 3'd2;
  localparam logic [2:0] F_REV    = 3'd3;
  localparam logic [2:0] F_ROTL   = 3'd4;
  localparam logic [2:0] F_ROTR   = 3'd5;
  localparam logic [2:0] F_READ   = 3'd6;
  localparam logic [2:0] F_UNUSED = 3'd7;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;

  typedef enum logic [1:0] {
    SEL_HOLD  = 2'd0,
    SEL_LEFT  = 2'd1,
    SEL_RIGHT = 2'd2,
    SEL_BCAST = 2'd3
  } sel_t;

  typedef struct packed {
    logic          start;
    logic [30:0]   dividend;
    logic [CW-1:0] divisor;
  } mod_ctl_t;

  typedef struct packed {
    logic          done;
    logic [CW-1:0] rem;
  } mod_sts_t;

endpackage

/* src/psb_cell.sv */
module psb_cell (
  input  logic                     clk,
  input  psb_pkg::sel_t            sel,
  input  logic [psb_pkg::DW-1:0]   left,
  input  logic [psb_pkg::DW-1:0]   right,
  input  logic [psb_pkg::DW-1:0]   bcast,
  output logic [psb_pkg::DW-1:0]   q
);

  logic [psb_pkg::DW-1:0] elem_r;
  logic [psb_pkg::DW-1:0] elem_nxt;

  always_comb begin
    unique case (sel)
      psb_pkg::SEL_HOLD:  elem_nxt = elem_r;
      psb_pkg::SEL_LEFT:  elem_nxt = left;
      psb_pkg::SEL_RIGHT: elem_nxt = right;
      psb_pkg::SEL_BCAST: elem_nxt = bcast;
      default:            elem_nxt = elem_r;
    endcase
  end

  always_ff @(posedge clk) begin
    elem_r <= elem_nxt;
  end

  assign q = elem_r;

endmodule

/* src/psb_mod.sv */
module psb_mod (
  input  logic              clk,
  input  logic              rst_n,
  input  psb_pkg::mod_ctl_t ctl,
  output psb_pkg::mod_sts_t sts
);

  logic [30:0]            d_r, d_nxt;
  logic [psb_pkg::CW-1:0] rem_r, rem_nxt;
  logic [psb_pkg::CW-1:0] div_r, div_nxt;
  logic [4:0]             bit_r, bit_nxt;
  logic                   busy_r, busy_nxt;
  logic                   done_r, done_nxt;
  logic [psb_pkg::CW:0]   trial;

  always_comb begin
    d_nxt    = d_r;
    rem_nxt  = rem_r;
    div_nxt  = div_r;
    bit_nxt  = bit_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial    = {rem_r, d_r[30]};
    if (ctl.start) begin
      d_nxt    = ctl.dividend;
      rem_nxt  = '0;
      div_nxt  = ctl.divisor;
      bit_nxt  = 5'd30;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      d_nxt = {d_r[29:0], 1'b0};
      if (trial >= {1'b0, div_r}) begin
        rem_nxt = psb_pkg::CW'(trial - {1'b0, div_r});
      end else begin
        rem_nxt = trial[psb_pkg::CW-1:0];
      end
      bit_nxt = bit_r - 5'd1;
      if (bit_r == 5'd0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    d_r   <= d_nxt;
    rem_r <= rem_nxt;
    div_r <= div_nxt;
    bit_r <= bit_nxt;
  end

  assign sts.done = done_r;
  assign sts.rem  = rem_r;

endmodule

/* src/positional_sequence_buffer.sv */
// Ordered list of up to CAPACITY signed 32-bit words held in a chain of cells, one entry per
// cell. After a word is taken, insert and remove change the list in the execute state, move
// adds a second state, reverse steps through the list, and rotate starts the modulo unit,
// waits for its remainder and shifts the chain one position per step. The done state loads the
// status word into the output register once it is free. Read all puts out one word per cycle
// from the head cell, while the output is not stalled, as the chain rotates back into place.
// A new input word is taken only when the previous operation has finished.
module positional_sequence_buffer #(
  parameter int CAPACITY = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // value[31:0], position[47:32], second_position[63:48], shift_amount[94:64], zero pad.
  input  logic [95:0] in_tdata,
  // func[2:0].
  input  logic [2:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // status[1:0], element[33:2], entry_count[40:34], zero pad.
  output logic [47:0] out_tdata,
  // element_valid.
  output logic        out_tuser,
  output logic        out_tlast
);

  localparam int CW = psb_pkg::CW;
  localparam int DW = psb_pkg::DW;
  localparam logic [CW-1:0] CAP = CW'(CAPACITY);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_EXEC  = 8'b0000_0010,
    S_MOVE2 = 8'b0000_0100,
    S_REV   = 8'b0000_1000,
    S_DIV   = 8'b0001_0000,
    S_ROT   = 8'b0010_0000,
    S_READ  = 8'b0100_0000,
    S_DONE  = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;
  logic [2:0]    func_r, func_nxt;
  logic [DW-1:0] val_r, val_nxt;
  logic [15:0]   pos_r, pos_nxt;
  logic [15:0]   pos2_r, pos2_nxt;
  logic [30:0]   shift_r, shift_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [CW-1:0] k_r, k_nxt;
  logic [CW-1:0] s_r, s_nxt;
  logic [DW-1:0] moved_r, moved_nxt;
  logic [1:0]    st_r, st_nxt;

  logic          ov_r, ov_nxt;
  logic [1:0]    ost_r, ost_nxt;
  logic [DW-1:0] oel_r, oel_nxt;
  logic          ova_r, ova_nxt;
  logic [CW-1:0] ocnt_r, ocnt_nxt;
  logic          olast_r, olast_nxt;

  logic [DW-1:0] e [CAPACITY];
  psb_pkg::sel_t sel [CAPACITY];
  logic [DW-1:0] bcast;
  logic          ofree;
  logic [CW-1:0] ins_p;
  logic [CW-1:0] mv_q;
  logic [CW-1:0] cm1;
  psb_pkg::mod_ctl_t mctl;
  psb_pkg::mod_sts_t msts;

  assign ofree = !ov_r || out_tready;
  assign cm1   = cnt_r - CW'(1);
  assign ins_p = ({9'd0, cnt_r} < pos_r) ? cnt_r : pos_r[CW-1:0];
  assign mv_q  = ({9'd0, cm1} < pos2_r) ? cm1 : pos2_r[CW-1:0];

  genvar gi;
  generate
    for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
      logic [DW-1:0] lft, rgt;
      if (gi == 0) begin : g_l0
        assign lft = '0;
      end else begin : g_ln
        assign lft = e[gi-1];
      end
      if (gi == CAPACITY - 1) begin : g_rl
        assign rgt = '0;
      end else begin : g_rn
        assign rgt = e[gi+1];
      end
      psb_cell u_cell (
        .clk  (clk),
        .sel  (sel[gi]),
        .left (lft),
        .right(rgt),
        .bcast(bcast),
        .q    (e[gi])
      );
    end
  endgenerate

  psb_mod u_mod (
    .clk  (clk),
    .rst_n(rst_n),
    .ctl  (mctl),
    .sts  (msts)
  );

  always_comb begin
    state_nxt = state_r;
    func_nxt  = func_r;
    val_nxt   = val_r;
    pos_nxt   = pos_r;
    pos2_nxt  = pos2_r;
    shift_nxt = shift_r;
    cnt_nxt   = cnt_r;
    k_nxt     = k_r;
    s_nxt     = s_r;
    moved_nxt = moved_r;
    st_nxt    = st_r;
    ov_nxt    = ov_r && !out_tready;
    ost_nxt   = ost_r;
    oel_nxt   = oel_r;
    ova_nxt   = ova_r;
    ocnt_nxt  = ocnt_r;
    olast_nxt = olast_r;
    bcast     = val_r;
    mctl.start    = 1'b0;
    mctl.dividend = shift_r;
    mctl.divisor  = cnt_r;
    for (int i = 0; i < CAPACITY; i++) begin
      sel[i] = psb_pkg::SEL_HOLD;
    end
    in_tready = (state_r == S_IDLE);

    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          func_nxt  = in_tuser;
          val_nxt   = in_tdata[31:0];
          pos_nxt   = in_tdata[47:32];
          pos2_nxt  = in_tdata[63:48];
          shift_nxt = in_tdata[94:64];
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        st_nxt    = psb_pkg::ST_OK;
        state_nxt = S_DONE;
        unique case (func_r)
          psb_pkg::F_INSERT: begin
            if (cnt_r >= CAP) begin
              st_nxt = psb_pkg::ST_FULL;
            end else begin
              bcast = val_r;
              for (int i = 0; i < CAPACITY; i++) begin
                if (CW'(i) == ins_p) sel[i] = psb_pkg::SEL_BCAST;
                else if (CW'(i) > ins_p && CW'(i) <= cnt_r) sel[i] = psb_pkg::SEL_LEFT;
              end
              cnt_nxt = cnt_r + CW'(1);
            end
          end
          psb_pkg::F_REMOVE, psb_pkg::F_MOVE: begin
            if (pos_r >= {9'd0, cnt_r}) begin
              st_nxt = psb_pkg::ST_RANGE;
            end else begin
              moved_nxt = e[pos_r[$clog2(CAPACITY)-1:0]];
              for (int i = 0; i < CAPACITY; i++) begin
                if ({9'd0, CW'(i)} >= pos_r && CW'(i) < cm1) sel[i] = psb_pkg::SEL_RIGHT;
              end
              if (func_r == psb_pkg::F_REMOVE) cnt_nxt = cm1;
              else state_nxt = S_MOVE2;
            end
          end
          psb_pkg::F_REV: begin
            if (cnt_r > CW'(1)) begin
              k_nxt     = '0;
              state_nxt = S_REV;
            end
          end
          psb_pkg::F_ROTL, psb_pkg::F_ROTR: begin
            if (cnt_r != '0) begin
              mctl.start = 1'b1;
              state_nxt  = S_DIV;
            end
          end
          psb_pkg::F_READ: begin
            if (cnt_r == '0) begin
              st_nxt = psb_pkg::ST_RANGE;
            end else begin
              k_nxt     = '0;
              state_nxt = S_READ;
            end
          end
          default: begin
          end
        endcase
      end
      S_MOVE2: begin
        bcast = moved_r;
        for (int i = 0; i < CAPACITY; i++) begin
          if (CW'(i) == mv_q) sel[i] = psb_pkg::SEL_BCAST;
          else if (CW'(i) > mv_q && CW'(i) <= cm1) sel[i] = psb_pkg::SEL_LEFT;
        end
        state_nxt = S_DONE;
      end
      S_REV: begin
        bcast = e[cm1[$clog2(CAPACITY)-1:0]];
        for (int i = 0; i < CAPACITY; i++) begin
          if (CW'(i) == k_r) sel[i] = psb_pkg::SEL_BCAST;
          else if (CW'(i) > k_r && CW'(i) < cnt_r) sel[i] = psb_pkg::SEL_LEFT;
        end
        k_nxt = k_r + CW'(1);
        if (k_r == cnt_r - CW'(2)) state_nxt = S_DONE;
      end
      S_DIV: begin
        if (msts.done) begin
          if (func_r == psb_pkg::F_ROTR && msts.rem != '0) s_nxt = cnt_r - msts.rem;
          else s_nxt = msts.rem;
          k_nxt     = '0;
          state_nxt = S_ROT;
        end
      end
      S_ROT: begin
        if (k_r == s_r) begin
          state_nxt = S_DONE;
        end else begin
          bcast = e[0];
          for (int i = 0; i < CAPACITY; i++) begin
            if (CW'(i) < cm1) sel[i] = psb_pkg::SEL_RIGHT;
            else if (CW'(i) == cm1) sel[i] = psb_pkg::SEL_BCAST;
          end
          k_nxt = k_r + CW'(1);
        end
      end
      S_READ: begin
        if (ofree) begin
          ov_nxt    = 1'b1;
          ost_nxt   = psb_pkg::ST_OK;
          oel_nxt   = e[0];
          ova_nxt   = 1'b1;
          ocnt_nxt  = cnt_r;
          olast_nxt = (k_r == cm1);
          bcast     = e[0];
          for (int i = 0; i < CAPACITY; i++) begin
            if (CW'(i) < cm1) sel[i] = psb_pkg::SEL_RIGHT;
            else if (CW'(i) == cm1) sel[i] = psb_pkg::SEL_BCAST;
          end
          k_nxt = k_r + CW'(1);
          if (k_r == cm1) state_nxt = S_IDLE;
        end
      end
      S_DONE: begin
        if (ofree) begin
          ov_nxt    = 1'b1;
          ost_nxt   = st_r;
          oel_nxt   = '0;
          ova_nxt   = 1'b0;
          ocnt_nxt  = cnt_r;
          olast_nxt = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      ov_r    <= ov_nxt;
    end
    func_r  <= func_nxt;
    val_r   <= val_nxt;
    pos_r   <= pos_nxt;
    pos2_r  <= pos2_nxt;
    shift_r <= shift_nxt;
    k_r     <= k_nxt;
    s_r     <= s_nxt;
    moved_r <= moved_nxt;
    st_r    <= st_nxt;
    ost_r   <= ost_nxt;
    oel_r   <= oel_nxt;
    ova_r   <= ova_nxt;
    ocnt_r  <= ocnt_nxt;
    olast_r <= olast_nxt;
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = {7'd0, ocnt_r, oel_r, ost_r};
  assign out_tuser  = ova_r;
  assign out_tlast  = olast_r;

`ifndef NO_ASSERTIONS
  a_cnt_cap: assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= CAP)
    else $error("entry count above capacity");
  a_onehot: assert property (@(posedge clk) disable iff (!rst_n) $onehot(state_r))
    else $error("state not one-hot");
  a_ins_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EXEC && func_r == psb_pkg::F_INSERT && cnt_r < CAP)
      |=> cnt_r == $past(cnt_r) + CW'(1))
    else $error("insert did not grow the list");
  a_rot_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ROT || state_r == S_REV || state_r == S_READ) |=> $stable(cnt_r))
    else $error("count changed during a shuffle");
`endif

endmodule

/* bench/tb_positional_sequence_buffer.sv */
module tb_positional_sequence_buffer;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CAP = 32;
  localparam int WATCHDOG_LIMIT = 20000;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] element;
    logic        element_valid;
    logic [6:0]  entry_count;
    logic        last;
  } list_result_t;

  class list_scoreboard;
    logic [31:0] entries[$];
    list_result_t pending[$];
    int errors;
    int results_seen;

    function void push_status(logic [1:0] st);
      list_result_t r;
      r.status = st;
      r.element = '0;
      r.element_valid = 1'b0;
      r.entry_count = 7'(entries.size());
      r.last = 1'b1;
      pending.push_back(r);
    endfunction

    function void note_input(logic [2:0] fn, logic [31:0] val, logic [15:0] pos,
                             logic [15:0] pos2, logic [30:0] shamt);
      int n;
      int s;
      int dst;
      logic [31:0] moved;
      list_result_t r;
      n = entries.size();
      case (fn)
        psb_pkg::F_INSERT: begin
          if (n >= CAP) begin
            push_status(psb_pkg::ST_FULL);
          end else begin
            entries.insert((pos > n) ? n : int'(pos), val);
            push_status(psb_pkg::ST_OK);
          end
        end
        psb_pkg::F_REMOVE: begin
          if (pos >= n) begin
            push_status(psb_pkg::ST_RANGE);
          end else begin
            entries.delete(int'(pos));
            push_status(psb_pkg::ST_OK);
          end
        end
        psb_pkg::F_MOVE: begin
          if (pos >= n) begin
            push_status(psb_pkg::ST_RANGE);
          end else begin
            moved = entries[pos];
            entries.delete(int'(pos));
            dst = (pos2 > n - 1) ? n - 1 : int'(pos2);
            entries.insert(dst, moved);
            push_status(psb_pkg::ST_OK);
          end
        end
        psb_pkg::F_REV: begin
          entries.reverse();
          push_status(psb_pkg::ST_OK);
        end
        psb_pkg::F_ROTL, psb_pkg::F_ROTR: begin
          if (n > 0) begin
            s = int'(shamt % n);
            if (fn == psb_pkg::F_ROTR && s != 0) s = n - s;
            repeat (s) entries.push_back(entries.pop_front());
          end
          push_status(psb_pkg::ST_OK);
        end
        psb_pkg::F_READ: begin
          if (n == 0) begin
            push_status(psb_pkg::ST_RANGE);
          end else begin
            for (int i = 0; i < n; i++) begin
              r.status = psb_pkg::ST_OK;
              r.element = entries[i];
              r.element_valid = 1'b1;
              r.entry_count = 7'(n);
              r.last = (i == n - 1);
              pending.push_back(r);
            end
          end
        end
        default: push_status(psb_pkg::ST_OK);
      endcase
    endfunction

    function void check_result(list_result_t got);
      list_result_t exp_r;
      results_seen++;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result %p", $time, got);
        errors++;
        return;
      end
      exp_r = pending.pop_front();
      if (got !== exp_r) begin
        $display("%0t: mismatch expected %p actual %p", $time, exp_r, got);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [95:0] in_tdata = '0;
  logic [2:0] in_tuser = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [47:0] out_tdata;
  logic out_tuser;
  logic out_tlast;

  list_scoreboard sb;
  int idle_cycles = 0;
  int words_sent = 0;
  bit stall_on = 1'b0;
  int op_seen[8];

  always #6 clk = ~clk;

  positional_sequence_buffer #(.CAPACITY(CAP)) dut (.*);

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        sb.note_input(in_tuser, in_tdata[31:0], in_tdata[47:32], in_tdata[63:48],
                      in_tdata[94:64]);
        op_seen[in_tuser]++;
      end
      if (out_tvalid && out_tready)
        sb.check_result({out_tdata[1:0], out_tdata[33:2], out_tuser, out_tdata[40:34],
                         out_tlast});
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > WATCHDOG_LIMIT) begin
        $display("positional_sequence_buffer verification failed");
        $finish;
      end
    end
  end

  // The receiver alternates between stall-free stretches and bursty back-pressure.
  always @(posedge clk) begin
    if (($urandom % 64) == 0) stall_on <= ~stall_on;
    out_tready <= stall_on ? (($urandom % 3) == 0) : 1'b1;
  end

  task automatic send_word(logic [2:0] fn, logic [31:0] val, logic [15:0] pos,
                           logic [15:0] pos2, logic [30:0] shamt);
    in_tuser <= fn;
    in_tdata <= {1'b0, shamt, pos2, pos, val};
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    words_sent++;
  endtask

  task automatic gap();
    if (($urandom % 4) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  function automatic logic [15:0] rand_pos();
    int n;
    n = sb.entries.size();
    case ($urandom % 8)
      0: return 16'($urandom);
      1: return 16'hFFFF;
      2: return 16'(n);
      default: return 16'($urandom_range(0, (n > 0) ? n - 1 : 0));
    endcase
  endfunction

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  initial begin
    logic [2:0] fn;
    sb = new();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_word(psb_pkg::F_READ, 0, 0, 0, 0);
    send_word(psb_pkg::F_REMOVE, 0, 0, 0, 0);
    send_word(psb_pkg::F_MOVE, 0, 0, 0, 0);
    send_word(psb_pkg::F_REV, 0, 0, 0, 0);
    send_word(psb_pkg::F_ROTL, 0, 0, 0, 31'h7FFFFFFF);
    send_word(psb_pkg::F_ROTR, 0, 0, 0, 5);
    send_word(psb_pkg::F_INSERT, 32'h80000000, 0, 0, 0);
    send_word(psb_pkg::F_INSERT, 32'h7FFFFFFF, 16'hFFFF, 0, 0);
    send_word(psb_pkg::F_INSERT, 32'hFFFFFFFF, 0, 0, 0);
    send_word(psb_pkg::F_INSERT, 32'h00000001, 1, 0, 0);
    send_word(psb_pkg::F_MOVE, 0, 0, 16'hFFFF, 0);
    send_word(psb_pkg::F_MOVE, 0, 3, 0, 0);
    send_word(psb_pkg::F_MOVE, 0, 4, 0, 0);
    send_word(psb_pkg::F_REMOVE, 0, 16'hFFFF, 0, 0);
    send_word(psb_pkg::F_ROTL, 0, 0, 0, 8);
    send_word(psb_pkg::F_ROTR, 0, 0, 0, 31'h7FFFFFFF);
    send_word(psb_pkg::F_REV, 0, 0, 0, 0);
    send_word(psb_pkg::F_UNUSED, 32'hFFFFFFFF, 16'hFFFF, 16'hFFFF, 31'h7FFFFFFF);
    send_word(psb_pkg::F_READ, 0, 0, 0, 0);
    while (sb.entries.size() < CAP) send_word(psb_pkg::F_INSERT, $urandom, rand_pos(), 0, 0);
    send_word(psb_pkg::F_INSERT, 0, 0, 0, 0);
    send_word(psb_pkg::F_READ, 0, 0, 0, 0);
    wait_drained();

    for (int i = 0; i < 300; i++) begin
      case ($urandom % 16)
        0, 1, 2, 3, 4: fn = (sb.entries.size() > 24 && $urandom % 2) ?
                            psb_pkg::F_REMOVE : psb_pkg::F_INSERT;
        5, 6: fn = psb_pkg::F_REMOVE;
        7, 8: fn = psb_pkg::F_MOVE;
        9: fn = psb_pkg::F_REV;
        10: fn = psb_pkg::F_ROTL;
        11: fn = psb_pkg::F_ROTR;
        12, 13: fn = psb_pkg::F_READ;
        14: fn = psb_pkg::F_UNUSED;
        default: fn = psb_pkg::F_INSERT;
      endcase
      send_word(fn, $urandom, rand_pos(), rand_pos(),
                ($urandom % 2) ? 31'($urandom) : 31'($urandom_range(0, 70)));
      gap();
      if (i == 150) wait_drained();
    end

    wait_drained();
    $display("Sent %0d words: insert %0d remove %0d move %0d reverse %0d rotl %0d rotr %0d",
             words_sent, op_seen[0], op_seen[1], op_seen[2], op_seen[3], op_seen[4],
             op_seen[5]);
    $display("Read-all %0d, unused code %0d, %0d results checked.", op_seen[6], op_seen[7],
             sb.results_seen);
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("positional_sequence_buffer verification clean");
    else
      $display("positional_sequence_buffer verification failed");
    $finish;
  end
endmodule

/* files.f */
src/psb_pkg.sv
src/psb_cell.sv
src/psb_mod.sv
src/positional_sequence_buffer.sv
bench/tb_positional_sequence_buffer.sv
